/* rtl/dqs_pkg.sv */
// Shared constants, register codes and fixed-point helpers of the Q-sample converter.
package dqs_pkg;

  localparam int DEF_ANGLE_BITS  = 16;
  localparam int DEF_SIGNAL_BITS = 32;

  localparam int FRAC29 = 29;
  localparam logic signed [31:0] ONE29     = 32'sd536870912;
  localparam logic signed [31:0] PI29      = 32'sd1686629713;
  localparam logic signed [31:0] HALF_PI29 = 32'sd843314856;

  localparam logic [46:0] MASK47 = {47{1'b1}};

  // Result beat: q_x, q_y, q_z, weight, error_sq, scan, padded to bytes.
  localparam int OUT_W = 208;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_NUMBER = 3'd0,
    CFG_PARALLAX    = 3'd1,
    CFG_INV_WL3     = 3'd2,
    CFG_LORENTZ     = 3'd3,
    CFG_ROT_X       = 3'd4,
    CFG_ROT_Y       = 3'd5,
    CFG_ROT_Z       = 3'd6
  } cfg_idx_t;

  localparam logic [31:0] RST_WAVE_NUMBER = 32'd411775;
  localparam logic [15:0] RST_PARALLAX    = 16'd4096;
  localparam logic [31:0] RST_INV_WL3     = 32'd65536;
  localparam logic [47:0] RST_ROT_X       = 48'h0000_0000_4000;
  localparam logic [47:0] RST_ROT_Y       = 48'h0000_4000_0000;
  localparam logic [47:0] RST_ROT_Z       = 48'h4000_0000_0000;

  // Arithmetic right shift that rounds toward zero, as a signed divide by 2^sh.
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] p,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    bias = p[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (p + bias) >>> sh;
  endfunction

endpackage

/* rtl/dqs_sincos.sv */
// Pipelined sine and cosine of a Q.29 angle: range fold, then Horner Taylor steps.
module dqs_sincos import dqs_pkg::*; #(
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic signed [31:0]           sin_o,
  output logic signed [31:0]           cos_o
);

  localparam int STEPS = 7;
  localparam int SUBS  = 3 * STEPS;

  logic signed [31:0] z_w;
  assign z_w = {angle, {(32 - ANGLE_BITS){1'b0}}};

  // fold into [-pi/2, pi/2]
  logic signed [31:0] z_r;
  logic               neg_r;
  always_ff @(posedge clk) begin
    if (en) begin
      if (z_w > HALF_PI29) begin
        z_r   <= z_w - PI29;
        neg_r <= 1'b1;
      end else if (z_w < -HALF_PI29) begin
        z_r   <= z_w + PI29;
        neg_r <= 1'b1;
      end else begin
        z_r   <= z_w;
        neg_r <= 1'b0;
      end
    end
  end

  // z squared, Q.29, always non-negative and below 2^31
  logic signed [63:0] zz_w;
  logic        [30:0] z2_r;
  logic signed [31:0] zq_r;
  logic               nq_r;
  assign zz_w = z_r * z_r;
  always_ff @(posedge clk) begin
    if (en) begin
      z2_r <= zz_w[59:29];
      zq_r <= z_r;
      nq_r <= neg_r;
    end
  end

  // side values that ride along the Horner stages
  logic signed [31:0] zc_r  [SUBS];
  logic        [30:0] z2c_r [SUBS];
  logic               nc_r  [SUBS];
  always_ff @(posedge clk) begin
    if (en) begin
      zc_r[0]  <= zq_r;
      z2c_r[0] <= z2_r;
      nc_r[0]  <= nq_r;
      for (int j = 1; j < SUBS; j++) begin
        zc_r[j]  <= zc_r[j-1];
        z2c_r[j] <= z2c_r[j-1];
        nc_r[j]  <= nc_r[j-1];
      end
    end
  end

  logic signed [31:0] ts_r [STEPS];
  logic signed [31:0] tc_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int N  = STEPS - k;
    localparam int DS = 2 * N * (2 * N + 1);
    localparam int DC = (2 * N - 1) * (2 * N);
    localparam logic [31:0] MS  = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC  = 32'((64'd1 << 32) / DC);
    localparam logic [7:0]  DS8 = 8'(DS);
    localparam logic [7:0]  DC8 = 8'(DC);

    logic signed [31:0] ts_in, tc_in;
    logic        [30:0] z2_in;
    logic signed [63:0] ps_r, pc_r;
    logic signed [63:0] vs_w, vc_w, as_full, ac_full;
    logic        [30:0] as_w, ac_w, as_r, ac_r;
    logic               sgs_r, sgc_r;
    logic        [62:0] rs_r, rc_r;
    logic        [30:0] q0s_w, q0c_w, qs_w, qc_w;
    logic        [31:0] rems_w, remc_w;

    if (k == 0) begin : g_first
      assign ts_in = ONE29;
      assign tc_in = ONE29;
      assign z2_in = z2_r;
    end else begin : g_next
      assign ts_in = ts_r[k-1];
      assign tc_in = tc_r[k-1];
      assign z2_in = z2c_r[3*k-1];
    end

    // product with z^2
    always_ff @(posedge clk) begin
      if (en) begin
        ps_r <= $signed({1'b0, z2_in}) * ts_in;
        pc_r <= $signed({1'b0, z2_in}) * tc_in;
      end
    end

    // scale back, take magnitude, multiply by reciprocal of the divisor
    assign vs_w    = trunc_shr(ps_r, FRAC29);
    assign vc_w    = trunc_shr(pc_r, FRAC29);
    assign as_full = vs_w[63] ? -vs_w : vs_w;
    assign ac_full = vc_w[63] ? -vc_w : vc_w;
    assign as_w    = as_full[30:0];
    assign ac_w    = ac_full[30:0];
    always_ff @(posedge clk) begin
      if (en) begin
        as_r  <= as_w;
        ac_r  <= ac_w;
        sgs_r <= vs_w[63];
        sgc_r <= vc_w[63];
        rs_r  <= as_w * MS;
        rc_r  <= ac_w * MC;
      end
    end

    // quotient estimate is low by at most one: fix with the remainder
    assign q0s_w  = rs_r[62:32];
    assign q0c_w  = rc_r[62:32];
    assign rems_w = {1'b0, as_r} - q0s_w * DS8;
    assign remc_w = {1'b0, ac_r} - q0c_w * DC8;
    assign qs_w   = q0s_w + 31'(rems_w >= 32'(DS8));
    assign qc_w   = q0c_w + 31'(remc_w >= 32'(DC8));
    always_ff @(posedge clk) begin
      if (en) begin
        ts_r[k] <= sgs_r ? ONE29 + $signed({1'b0, qs_w}) : ONE29 - $signed({1'b0, qs_w});
        tc_r[k] <= sgc_r ? ONE29 + $signed({1'b0, qc_w}) : ONE29 - $signed({1'b0, qc_w});
      end
    end
  end

  // sine needs one more multiply by z
  logic signed [63:0] fp_r;
  logic signed [31:0] tcf_r;
  logic               nf_r;
  logic signed [63:0] s_w;
  always_ff @(posedge clk) begin
    if (en) begin
      fp_r  <= zc_r[SUBS-1] * ts_r[STEPS-1];
      tcf_r <= tc_r[STEPS-1];
      nf_r  <= nc_r[SUBS-1];
    end
  end

  assign s_w = trunc_shr(fp_r, FRAC29);
  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= nf_r ? -s_w[31:0] : s_w[31:0];
      cos_o <= nf_r ? -tcf_r : tcf_r;
    end
  end

endmodule

/* rtl/detector_angles_to_q_sample.sv */
// Top level: detector pixel angles and signal to sample-frame Q event.
// Throughput: one beat per cycle; the whole pipeline advances together and
//   holds only while a result beat sits on out_ and out_tready is low.
// Beats with pixel_signal <= 0 travel as bubbles and produce no result beat.
// Reset (rst_n low, synchronous) clears all valid bits and loads register defaults.
module detector_angles_to_q_sample import dqs_pkg::*; #(
  parameter  int ANGLE_BITS  = DEF_ANGLE_BITS,
  parameter  int SIGNAL_BITS = DEF_SIGNAL_BITS,
  localparam int IN_W        = ((2 * ANGLE_BITS + SIGNAL_BITS + 16 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata, low bit up: two_theta, azimuth, pixel_signal, scan_index, zero pad
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  // out_tdata, low bit up: q_x, q_y, q_z, event_weight, event_error_sq,
  // event_scan, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DLY  = 34;        // stages before the output register
  localparam int WTAP = 29;        // stage where f is ready for the weight multiply
  localparam int SB   = SIGNAL_BITS;
  localparam int AB   = ANGLE_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers; user must write only while the pipeline is empty; not gated.
  // ---------------------------------------------------------------------------
  logic signed [31:0] wave_r;
  logic signed [15:0] coeff_r;
  logic        [31:0] iwl3_r;
  logic               lorentz_r;
  logic        [47:0] rot_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r    <= RST_WAVE_NUMBER;
      coeff_r   <= RST_PARALLAX;
      iwl3_r    <= RST_INV_WL3;
      lorentz_r <= 1'b0;
      rot_r[0]  <= RST_ROT_X;
      rot_r[1]  <= RST_ROT_Y;
      rot_r[2]  <= RST_ROT_Z;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WAVE_NUMBER: wave_r    <= cfg_data[31:0];
        CFG_PARALLAX:    coeff_r   <= cfg_data[15:0];
        CFG_INV_WL3:     iwl3_r    <= cfg_data[31:0];
        CFG_LORENTZ:     lorentz_r <= cfg_data[0];
        CFG_ROT_X:       rot_r[0]  <= cfg_data;
        CFG_ROT_Y:       rot_r[1]  <= cfg_data;
        CFG_ROT_Z:       rot_r[2]  <= cfg_data;
        default: ;  // index beyond the list: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance: every stage moves unless the output beat is stuck.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  logic signed [AB-1:0] tt_w, az_w;
  logic signed [SB-1:0] sig_w;
  logic        [15:0]   scan_w;
  assign tt_w   = in_tdata[AB-1:0];
  assign az_w   = in_tdata[2*AB-1:AB];
  assign sig_w  = in_tdata[2*AB+SB-1:2*AB];
  assign scan_w = in_tdata[2*AB+SB+15:2*AB+SB];

  // stage 0 input register and the side-data delay line
  logic signed [AB-1:0] tt_r, az_r;
  logic                 vld_d  [DLY];
  logic signed [SB-1:0] sig_d  [DLY];
  logic        [15:0]   scan_d [DLY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLY; i++) begin
        vld_d[i] <= 1'b0;
      end
    end else if (adv) begin
      // drop non-positive signal right at the door
      vld_d[0] <= in_tvalid && (sig_w > 0);
      for (int i = 1; i < DLY; i++) begin
        vld_d[i] <= vld_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tt_r      <= tt_w;
      az_r      <= az_w;
      sig_d[0]  <= sig_w;
      scan_d[0] <= scan_w;
      for (int i = 1; i < DLY; i++) begin
        sig_d[i]  <= sig_d[i-1];
        scan_d[i] <= scan_d[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1..25: sine and cosine of both angles, side by side.
  // ---------------------------------------------------------------------------
  logic signed [31:0] s2t_w, c2t_w, sp_w, cp_w;

  dqs_sincos #(.ANGLE_BITS(AB)) u_sc_tt (
    .clk   (clk),
    .en    (adv),
    .angle (tt_r),
    .sin_o (s2t_w),
    .cos_o (c2t_w)
  );

  dqs_sincos #(.ANGLE_BITS(AB)) u_sc_az (
    .clk   (clk),
    .en    (adv),
    .angle (az_r),
    .sin_o (sp_w),
    .cos_o (cp_w)
  );

  // stage 26: sin2t*cos(p), sin2t*sin(p), 1-cos2t
  logic signed [63:0] scp_r, ssp_r;
  logic signed [31:0] omc_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      scp_r <= s2t_w * cp_w;
      ssp_r <= s2t_w * sp_w;
      omc_r <= ONE29 - c2t_w;
    end
  end

  // stage 27: scale back to Q.29
  logic signed [63:0] sc_w, ss_w;
  logic signed [31:0] sc_r, ss_r, omc2_r;
  assign sc_w = trunc_shr(scp_r, FRAC29);
  assign ss_w = trunc_shr(ssp_r, FRAC29);
  always_ff @(posedge clk) begin
    if (adv) begin
      sc_r   <= sc_w[31:0];
      ss_r   <= ss_w[31:0];
      omc2_r <= omc_r;
    end
  end

  // stage 28: times wave number, Lorentz raw product
  logic        [31:0] sc_abs_w;
  logic signed [63:0] sck_r, ssk_r, zck_r;
  logic        [63:0] fp_r;
  assign sc_abs_w = sc_r[31] ? 32'(-sc_r) : 32'(sc_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      sck_r <= sc_r * wave_r;
      ssk_r <= ss_r * wave_r;
      zck_r <= omc2_r * wave_r;
      fp_r  <= sc_abs_w * iwl3_r;
    end
  end

  // stage 29: lab x and z, negated y before parallax, factor f (Q16.16)
  logic signed [63:0] l0_w, m_w, l2_w;
  logic signed [39:0] lab0_r, m_r, lab2_r;
  logic        [34:0] f_r;
  assign l0_w = trunc_shr(sck_r, FRAC29);
  assign m_w  = trunc_shr(ssk_r, FRAC29);
  assign l2_w = trunc_shr(zck_r, FRAC29);
  always_ff @(posedge clk) begin
    if (adv) begin
      lab0_r <= -l0_w[39:0];
      m_r    <= -m_w[39:0];
      lab2_r <= l2_w[39:0];
      f_r    <= lorentz_r ? fp_r[63:29] : 35'd65536;
    end
  end

  // stage 30: parallax product, weight partial products
  logic        [63:0] sig64_w;
  logic signed [63:0] l1p_r;
  logic signed [39:0] lab0_f_r, lab2_f_r;
  logic        [66:0] wlo_r, whi_r;
  logic        [34:0] f_f_r;
  assign sig64_w = 64'($unsigned(sig_d[WTAP]));
  always_ff @(posedge clk) begin
    if (adv) begin
      l1p_r    <= m_r * coeff_r;
      lab0_f_r <= lab0_r;
      lab2_f_r <= lab2_r;
      wlo_r    <= sig64_w[31:0] * f_r;
      whi_r    <= sig64_w[63:32] * f_r;
      f_f_r    <= f_r;
    end
  end

  // stage 31: lab y, weight assembled; a weight past 64 (47) bits pins weff (w47) at all ones
  logic signed [63:0] l1_w;
  logic        [98:0] wprod_w;
  logic        [82:0] wfull_w;
  logic signed [39:0] lab_r [3];
  logic        [63:0] weff_r;
  logic        [46:0] w47_r;
  logic        [34:0] f_g_r;
  assign l1_w    = trunc_shr(l1p_r, 12);
  assign wprod_w = 99'(wlo_r) + (99'(whi_r) << 32);
  assign wfull_w = wprod_w[98:16];
  always_ff @(posedge clk) begin
    if (adv) begin
      lab_r[0] <= lab0_f_r;
      lab_r[1] <= l1_w[39:0];
      lab_r[2] <= lab2_f_r;
      weff_r   <= (|wfull_w[82:64]) ? {64{1'b1}} : wfull_w[63:0];
      w47_r    <= (|wfull_w[82:47]) ? MASK47 : wfull_w[46:0];
      f_g_r    <= f_f_r;
    end
  end

  // stage 32: matrix partial products, error partial products
  logic signed [55:0] mp_r [3][3];
  logic        [66:0] elo_r, ehi_r;
  logic        [46:0] w47_h_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          mp_r[r][j] <= $signed(rot_r[r][16*j +: 16]) * lab_r[j];
        end
      end
      elo_r   <= weff_r[31:0] * f_g_r;
      ehi_r   <= weff_r[63:32] * f_g_r;
      w47_h_r <= w47_r;
    end
  end

  // stage 33: row sums, error assembled and clamped
  logic signed [63:0] sum_r [3];
  logic        [98:0] eprod_w;
  logic        [82:0] efull_w;
  logic        [46:0] e47_r, w47_i_r;
  assign eprod_w = 99'(elo_r) + (99'(ehi_r) << 32);
  assign efull_w = eprod_w[98:16];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        sum_r[r] <= 64'(mp_r[r][0]) + 64'(mp_r[r][1]) + 64'(mp_r[r][2]);
      end
      e47_r   <= (|efull_w[82:47]) ? MASK47 : efull_w[46:0];
      w47_i_r <= w47_h_r;
    end
  end

  // stage 34: scale by 2^-14, saturate, output register
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  logic signed [31:0] q_w [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      q_w[r] = sat32(trunc_shr(sum_r[r], 14));
    end
  end

  logic [OUT_W-1:0] out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_d[DLY-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {2'b00, scan_d[DLY-1], e47_r, w47_i_r, q_w[2], q_w[1], q_w[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/dqs_checker.sv */
// Port-level checker for the Q-sample converter, bound to the top level.
module dqs_checker import dqs_pkg::*; #(
  parameter  int ANGLE_BITS  = DEF_ANGLE_BITS,
  parameter  int SIGNAL_BITS = DEF_SIGNAL_BITS,
  localparam int IN_W        = ((2 * ANGLE_BITS + SIGNAL_BITS + 16 + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_W-1:0]       in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_W-1:0]      out_tdata,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // input side takes beats exactly when the output stage can move
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow the output stage");

  // zero weight implies zero error
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[142:96] == 47'd0) |-> (out_tdata[189:143] == 47'd0))
    else $error("nonzero error with zero weight");

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

endmodule

bind detector_angles_to_q_sample dqs_checker #(
  .ANGLE_BITS  (ANGLE_BITS),
  .SIGNAL_BITS (SIGNAL_BITS)
) u_dqs_checker (.*);
